[rtl/core/cts_pkg.sv]
package cts_pkg;

    localparam int QDEPTH  = 8;
    localparam int QIDX_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QFILL_W = $clog2(QDEPTH + 1);
    localparam int QSUM_W  = QFILL_W + 1;

    localparam logic [7:0] COUNT_CEIL = 8'hFF;

    typedef enum logic [1:0] {
        CMD_REQ  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_ACK_START = 2'd1,
        PH_TIMER     = 2'd2,
        PH_ACK_TIMER = 2'd3
    } phase_t;

    typedef enum logic {
        CS_ACCEPT = 1'b0,
        CS_EXEC   = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic [15:0] period;
        logic [7:0]  count;
        logic [7:0]  target;
    } job_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? COUNT_CEIL : s[7:0];
    endfunction

    // Reduces a sum below twice the depth to a queue slot index.
    function automatic logic [QIDX_W-1:0] qwrap(input logic [QSUM_W-1:0] s);
        logic [QSUM_W-1:0] r;
        r = (s >= QSUM_W'(QDEPTH)) ? s - QSUM_W'(QDEPTH) : s;
        return r[QIDX_W-1:0];
    endfunction

    function automatic logic [15:0] load_value(input logic [15:0] p);
        return (p == 16'd0) ? 16'd1 : p;
    endfunction

endpackage

[rtl/core/cts_ctrl.sv]
module cts_ctrl import cts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic       slot_free;

    // The result slot is free when empty or being drained at this edge.
    assign slot_free = !status.out_valid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_ACCEPT: begin
                if (s_tvalid && slot_free) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                state_next = CS_ACCEPT;
            end
            default: begin
                state_next = CS_ACCEPT;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            CS_ACCEPT: begin
                s_tready    = slot_free;
                cmd.capture = s_tvalid && slot_free;
            end
            CS_EXEC: begin
                cmd.exec = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/cts_datapath.sv]
module cts_datapath import cts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [31:0] in_data,
    input  logic [1:0]  in_kind,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    job_t mem [QDEPTH];

    // Algorithm state.
    phase_t              phase_reg, phase_next;
    logic [7:0]          run_target_reg, run_target_next;
    logic [7:0]          run_rem_reg, run_rem_next;
    logic [15:0]         run_period_reg, run_period_next;
    logic [15:0]         countdown_reg, countdown_next;
    logic [QIDX_W-1:0]   head_reg, head_next;
    logic [QFILL_W-1:0]  fill_reg, fill_next;

    // Captured transaction and queue read.
    cmd_t                kind_reg;
    logic [7:0]          tid_reg;
    logic [7:0]          cnt_reg;
    logic [15:0]         per_reg;
    logic [QIDX_W-1:0]   raddr_reg;
    job_t                rd_reg;

    // Result register.
    logic                out_valid_reg;
    logic [18:0]         out_reg, out_next;

    logic                we;
    logic [QIDX_W-1:0]   waddr;
    job_t                wdata;
    logic [QIDX_W-1:0]   tail_idx, slot_idx, raddr;
    logic [7:0]          ack_rem;
    logic                accepted, iv;
    logic [7:0]          it, itimes;

    assign tail_idx = qwrap(QSUM_W'(head_reg) + QSUM_W'(fill_reg) - QSUM_W'(1));
    assign slot_idx = qwrap(QSUM_W'(head_reg) + QSUM_W'(fill_reg));
    assign raddr    = (cmd_t'(in_kind) == CMD_REQ) ? tail_idx : head_reg;
    assign ack_rem  = (cnt_reg >= run_rem_reg) ? 8'd0 : run_rem_reg - cnt_reg;

    // The queue is written only in the update cycle of a transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= cmd_t'(in_kind);
            tid_reg   <= in_data[7:0];
            cnt_reg   <= in_data[15:8];
            per_reg   <= in_data[31:16];
            raddr_reg <= raddr;
            rd_reg    <= mem[raddr];
        end
        if (cmd.exec && we) begin
            mem[waddr] <= wdata;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        run_target_next = run_target_reg;
        run_rem_next    = run_rem_reg;
        run_period_next = run_period_reg;
        countdown_next  = countdown_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        we              = 1'b0;
        waddr           = slot_idx;
        wdata           = '{period: per_reg, count: cnt_reg, target: tid_reg};
        accepted        = 1'b1;
        iv              = 1'b0;
        it              = 8'd0;
        itimes          = 8'd0;

        unique case (kind_reg)
            CMD_REQ: begin
                if (tid_reg != 8'd0 && cnt_reg != 8'd0) begin
                    priority if (phase_reg == PH_IDLE) begin
                        run_target_next = tid_reg;
                        run_rem_next    = cnt_reg;
                        run_period_next = per_reg;
                        phase_next      = PH_ACK_START;
                        iv              = 1'b1;
                        it              = tid_reg;
                        itimes          = cnt_reg;
                    end else if (fill_reg == '0) begin
                        if (run_target_reg == tid_reg && run_period_reg == per_reg) begin
                            run_rem_next = sat_add(run_rem_reg, cnt_reg);
                        end else begin
                            we        = 1'b1;
                            waddr     = head_reg;
                            fill_next = QFILL_W'(1);
                        end
                    end else if (rd_reg.target == tid_reg && rd_reg.period == per_reg) begin
                        we          = 1'b1;
                        waddr       = raddr_reg;
                        wdata.count = sat_add(rd_reg.count, cnt_reg);
                    end else if (fill_reg < QFILL_W'(QDEPTH)) begin
                        we        = 1'b1;
                        waddr     = slot_idx;
                        fill_next = fill_reg + QFILL_W'(1);
                    end else begin
                        accepted = 1'b0;
                    end
                end
            end
            CMD_TICK: begin
                if (phase_reg == PH_TIMER) begin
                    if (countdown_reg <= 16'd1) begin
                        countdown_next = 16'd0;
                        phase_next     = PH_ACK_TIMER;
                        iv             = 1'b1;
                        it             = run_target_reg;
                        itimes         = run_rem_reg;
                    end else begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            CMD_ACK: begin
                if (phase_reg == PH_ACK_START || phase_reg == PH_ACK_TIMER) begin
                    priority if (ack_rem != 8'd0) begin
                        run_rem_next   = ack_rem;
                        phase_next     = PH_TIMER;
                        countdown_next = load_value(run_period_reg);
                    end else if (fill_reg != '0) begin
                        // rd_reg holds the head entry read at capture.
                        run_target_next = rd_reg.target;
                        run_rem_next    = rd_reg.count;
                        run_period_next = rd_reg.period;
                        head_next       = qwrap(QSUM_W'(head_reg) + QSUM_W'(1));
                        fill_next       = fill_reg - QFILL_W'(1);
                        phase_next      = PH_TIMER;
                        countdown_next  = load_value(rd_reg.period);
                    end else begin
                        phase_next      = PH_IDLE;
                        run_target_next = 8'd0;
                        run_rem_next    = 8'd0;
                        run_period_next = 16'd0;
                        countdown_next  = 16'd0;
                    end
                end
            end
            CMD_RSVD: begin
                accepted = 1'b1;
            end
            default: begin
                accepted = 1'b1;
            end
        endcase

        out_next = {(phase_next != PH_IDLE), itimes, it, iv, accepted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            run_target_reg <= 8'd0;
            run_rem_reg    <= 8'd0;
            run_period_reg <= 16'd0;
            countdown_reg  <= 16'd0;
            head_reg       <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.exec) begin
                phase_reg      <= phase_next;
                run_target_reg <= run_target_next;
                run_rem_reg    <= run_rem_next;
                run_period_reg <= run_period_next;
                countdown_reg  <= countdown_next;
                head_reg       <= head_next;
                fill_reg       <= fill_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = {5'd0, out_reg};
    assign status.out_valid = out_valid_reg;

endmodule

[rtl/core/coalescing_tap_scheduler_core.sv]
// Coalescing tap scheduler.
// The s_ channel carries one transaction per event: s_tuser selects a tap
// request, a one-millisecond tick or an acknowledge of issued taps, and
// s_tdata carries the target id, the tap count and the period. Every
// transaction yields exactly one result transaction on the m_ channel with
// the accepted flag, an optional tap issue (target and times) and the busy
// flag after the event.
// A transaction is captured, and the job queue read, at the accepting
// edge; the state update and the result load follow in the cycle after.
// No new transaction is taken while one is in its update cycle, as the
// job queue memory is read through a register ahead of that cycle.
// A new transaction is accepted while the previous result still waits, as
// long as that result is taken in the same cycle; if m_tready stays low the
// result holds and s_tready stays low.
// Reset clears the scheduler to idle with an empty job queue; no clearing
// pass is needed, and the block accepts transactions right after reset.
module coalescing_tap_scheduler_core import cts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // target_id[7:0], count[15:8], period_ms[31:16]
    input  logic [1:0]  s_tuser,  // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // accepted[0], issue_valid[1], issue_target[9:2],
                                  // issue_times[17:10], busy_res[18], zero fill
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cts_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .in_kind  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
